@@ rtl/dqrh_pkg.sv @@
// Shared types, codes and reset values of the double rolling hash deque.
`timescale 1ns / 1ps
package dqrh_pkg;

   localparam int DataW   = 32;
   localparam int HashW   = 31;
   localparam int KindW   = 3;
   localparam int StatW   = 2;
   localparam int PosW    = 10;
   localparam int LenW    = 11;
   localparam int CsrIdxW = 3;

   typedef logic [HashW-1:0]   residue_type;
   typedef logic [DataW-1:0]   data_type;
   typedef logic [KindW-1:0]   kind_type;
   typedef logic [StatW-1:0]   stat_type;
   typedef logic [CsrIdxW-1:0] csr_idx_type;

   // operation codes
   localparam kind_type KIND_ADD_BACK   = 3'd0;
   localparam kind_type KIND_ADD_FRONT  = 3'd1;
   localparam kind_type KIND_DROP_BACK  = 3'd2;
   localparam kind_type KIND_DROP_FRONT = 3'd3;
   localparam kind_type KIND_SET        = 3'd4;
   localparam kind_type KIND_READ       = 3'd5;
   localparam kind_type KIND_CLEAR      = 3'd6;

   // status codes
   localparam stat_type STAT_OK      = 2'd0;
   localparam stat_type STAT_EMPTY   = 2'd1;
   localparam stat_type STAT_FULL    = 2'd2;
   localparam stat_type STAT_BAD_POS = 2'd3;

   // register indexes
   localparam csr_idx_type CSR_MOD_ONE = 3'd0;
   localparam csr_idx_type CSR_MOD_TWO = 3'd1;
   localparam csr_idx_type CSR_BASE    = 3'd2;
   localparam csr_idx_type CSR_INV_ONE = 3'd3;
   localparam csr_idx_type CSR_INV_TWO = 3'd4;

   localparam residue_type RST_MOD_ONE = 31'd1000000007;
   localparam residue_type RST_MOD_TWO = 31'd998244353;
   localparam residue_type RST_BASE    = 31'd2;
   localparam residue_type RST_INV_ONE = 31'd500000004;
   localparam residue_type RST_INV_TWO = 31'd499122177;

endpackage

@@ rtl/dqrh_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module dqrh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/deque_double_rolling_hash_core.sv @@
// Top level: deque with two polynomial rolling hashes and a shared modular multiplier.
`timescale 1ns / 1ps
// Deque of up to MAX_LEN 32-bit words with two rolling hashes
// H = sum s[i]*base^(n-1-i), one per modulus. An item is taken when start is
// high and busy is low; its single result shows for exactly one cycle with
// rsp_valid, which the receiver cannot stall. All modular multiplications run
// on one bit-serial multiply/reduce unit, used for the first modulus and then
// the second; modular sums and differences are combinational. Clear rebuilds
// both power tables, each entry past entry zero by one unit pass. The same
// build runs once after reset (busy throughout, no response); register
// writes are taken meanwhile and apply from the next item.
module deque_double_rolling_hash_core #(
   parameter int MAX_LEN = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  dqrh_pkg::kind_type    req_kind,
   input  dqrh_pkg::data_type    req_value,
   input  logic [9:0]            req_position,
   output logic                  rsp_valid,
   output dqrh_pkg::stat_type    rsp_status,
   output dqrh_pkg::residue_type rsp_hash_one,
   output dqrh_pkg::residue_type rsp_hash_two,
   output logic [10:0]           rsp_length,
   output dqrh_pkg::data_type    rsp_read_value,
   input  logic                  csr_wr_en,
   input  dqrh_pkg::csr_idx_type csr_index,
   input  dqrh_pkg::residue_type csr_wr_data
);

   import dqrh_pkg::*;

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int PW = (CW > PosW) ? CW : PosW;
   localparam logic [CW-1:0] LEN_MAX  = CW'(MAX_LEN);
   localparam logic [AW-1:0] LAST_IDX = AW'(MAX_LEN - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_WAIT, S_CAPT, S_LOAD, S_RUN, S_FINAL, S_COMMIT, S_FIN
   } state_type;

   // hash phases per modulus, then table-build phases
   typedef enum logic [2:0] {
      PH_H, PH_Y, PH_Z, PH_X, PH_M, PH_RB, PH_PW
   } phase_type;

   // ---------------- registers ----------------
   state_type   state_ff;
   phase_type   phase_ff;
   logic        side_ff;       // 0: first modulus, 1: second
   logic        boot_ff;       // table build after reset, no response
   logic [AW-1:0] idx_ff;

   residue_type mod1_ff, mod2_ff, base_ff, inv1_ff, inv2_ff;     // CSRs
   residue_type wm1_ff, wm2_ff, wbase_ff, winv1_ff, winv2_ff;    // working copies

   logic [AW-1:0] head_ff;
   logic [CW-1:0] cnt_ff;
   residue_type h1_ff, h2_ff;

   kind_type    kind_ff;
   data_type    val_ff;
   logic [AW-1:0] addr_ff, paddr_ff;
   data_type    e_ff;
   residue_type p1_ff, p2_ff;
   residue_type hr_ff, y_ff, z_ff, x_ff, t_ff;
   residue_type rb1_ff, rb2_ff, prev1_ff, prev2_ff;

   residue_type acc_ff, eb_ff;
   data_type    ea_ff;
   logic [4:0]  bit_ff;

   logic        rsp_valid_ff;
   stat_type    status_ff;
   data_type    rd_ff;

   // ---------------- memories ----------------
   data_type    st_rdata;
   residue_type pw1_rdata, pw2_rdata;
   logic        st_we, pw1_we, pw2_we;
   residue_type pw_wdata;

   dqrh_ram #(.WIDTH(DataW), .DEPTH(MAX_LEN)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(addr_ff), .wr_data(val_ff),
      .rd_addr(addr_ff), .rd_data(st_rdata)
   );

   dqrh_ram #(.WIDTH(HashW), .DEPTH(MAX_LEN)) u_pow_one (
      .clock(clock), .wr_en(pw1_we), .wr_addr(idx_ff), .wr_data(pw_wdata),
      .rd_addr(paddr_ff), .rd_data(pw1_rdata)
   );

   dqrh_ram #(.WIDTH(HashW), .DEPTH(MAX_LEN)) u_pow_two (
      .clock(clock), .wr_en(pw2_we), .wr_addr(idx_ff), .wr_data(pw_wdata),
      .rd_addr(paddr_ff), .rd_data(pw2_rdata)
   );

   // ---------------- helpers ----------------
   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] b,
                                              input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(b) + (CW+1)'(off);
      if (sum >= (CW+1)'(MAX_LEN)) sum = sum - (CW+1)'(MAX_LEN);
      return sum[AW-1:0];
   endfunction

   // operands already below m
   function automatic residue_type add_mod(input residue_type a, input residue_type b,
                                           input residue_type m);
      logic [HashW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[HashW-1:0];
   endfunction

   function automatic residue_type sub_mod(input residue_type a, input residue_type b,
                                           input residue_type m);
      logic [HashW:0] s;
      if (a >= b) s = {1'b0, a} - {1'b0, b};
      else        s = {1'b0, a} + {1'b0, m} - {1'b0, b};
      return s[HashW-1:0];
   endfunction

   // ---------------- modulus select ----------------
   residue_type mz1, mz2, mz, one1, one2, one_m;
   assign mz1   = (wm1_ff == '0) ? residue_type'(1) : wm1_ff;   // zero acts as one
   assign mz2   = (wm2_ff == '0) ? residue_type'(1) : wm2_ff;
   assign one1  = (mz1 == residue_type'(1)) ? '0 : residue_type'(1);
   assign one2  = (mz2 == residue_type'(1)) ? '0 : residue_type'(1);
   assign mz    = side_ff ? mz2 : mz1;
   assign one_m = side_ff ? one2 : one1;

   // ---------------- shared serial unit ----------------
   // acc = 2*acc + abit*b (mod m), MSB first; b must be below m.
   logic [HashW:0] dbl, dred, ssum, sred;
   residue_type    addend, step_res;
   always_comb begin
      dbl      = {acc_ff, 1'b0};
      dred     = (dbl >= {1'b0, mz}) ? dbl - {1'b0, mz} : dbl;
      addend   = ea_ff[DataW-1] ? eb_ff : '0;
      ssum     = {1'b0, dred[HashW-1:0]} + {1'b0, addend};
      sred     = (ssum >= {1'b0, mz}) ? ssum - {1'b0, mz} : ssum;
      step_res = sred[HashW-1:0];
   end

   // ---------------- phase operand loader ----------------
   residue_type dd, hnew;
   logic        ld_apply;
   data_type    ld_a;
   residue_type ld_b;

   assign dd = (kind_ff == KIND_SET) ? sub_mod(y_ff, z_ff, mz) : sub_mod(hr_ff, y_ff, mz);

   always_comb begin
      ld_apply = 1'b0;
      ld_a     = '0;
      ld_b     = one_m;   // multiply by one reduces
      case (phase_ff)
         PH_H: begin
            ld_apply = 1'b1;
            ld_a     = {1'b0, side_ff ? h2_ff : h1_ff};
         end
         PH_Y: begin
            case (kind_ff)
               KIND_ADD_BACK, KIND_SET: begin
                  ld_apply = 1'b1;
                  ld_a     = val_ff;
               end
               KIND_DROP_BACK: begin
                  ld_apply = 1'b1;
                  ld_a     = e_ff;
               end
               default: ;
            endcase
         end
         PH_Z: begin
            ld_apply = (kind_ff == KIND_SET);
            ld_a     = e_ff;
         end
         PH_X: begin
            ld_apply = 1'b1;
            case (kind_ff)
               KIND_ADD_BACK:  ld_a = {1'b0, wbase_ff};
               KIND_DROP_BACK: ld_a = {1'b0, side_ff ? winv2_ff : winv1_ff};
               default:        ld_a = {1'b0, side_ff ? p2_ff : p1_ff};
            endcase
         end
         PH_M: begin
            ld_apply = 1'b1;
            ld_b     = x_ff;
            case (kind_ff)
               KIND_ADD_BACK:   ld_a = {1'b0, hr_ff};
               KIND_ADD_FRONT:  ld_a = val_ff;
               KIND_DROP_FRONT: ld_a = e_ff;
               default:         ld_a = {1'b0, dd};
            endcase
         end
         PH_RB: begin
            ld_apply = 1'b1;
            ld_a     = {1'b0, wbase_ff};
         end
         PH_PW: begin
            ld_apply = (idx_ff != '0);
            ld_a     = {1'b0, side_ff ? prev2_ff : prev1_ff};
            ld_b     = side_ff ? rb2_ff : rb1_ff;
         end
         default: ;
      endcase
   end

   // new hash for the current modulus
   always_comb begin
      case (kind_ff)
         KIND_ADD_BACK:   hnew = add_mod(t_ff, y_ff, mz);
         KIND_DROP_BACK:  hnew = t_ff;
         KIND_DROP_FRONT: hnew = sub_mod(hr_ff, t_ff, mz);
         default:         hnew = add_mod(hr_ff, t_ff, mz);
      endcase
   end

   function automatic phase_type next_phase(input phase_type p);
      case (p)
         PH_H:    return PH_Y;
         PH_Y:    return PH_Z;
         PH_Z:    return PH_X;
         default: return PH_M;
      endcase
   endfunction

   logic run_done;
   assign run_done = (state_ff == S_RUN) && (bit_ff == '0);

   // power table writes: entry 0 is one, later entries from the unit
   logic pw_wr;
   assign pw_wr    = (phase_ff == PH_PW) &&
                     (((state_ff == S_LOAD) && (idx_ff == '0)) || run_done);
   assign pw1_we   = pw_wr && !side_ff;
   assign pw2_we   = pw_wr && side_ff;
   assign pw_wdata = (state_ff == S_LOAD) ? one_m : step_res;

   assign st_we = (state_ff == S_COMMIT) &&
                  ((kind_ff == KIND_ADD_BACK) || (kind_ff == KIND_ADD_FRONT) ||
                   (kind_ff == KIND_SET));

   // ---------------- accept decode ----------------
   logic [CW-1:0] cnt_m1, k_off;
   logic          bad_pos;
   stat_type      acc_status;
   logic [AW-1:0] acc_addr, acc_paddr;
   logic          acc_run;

   assign cnt_m1  = cnt_ff - CW'(1);
   assign k_off   = cnt_m1 - CW'(req_position);
   assign bad_pos = PW'(req_position) >= PW'(cnt_ff);

   always_comb begin
      acc_status = STAT_OK;
      acc_addr   = head_ff;
      acc_paddr  = '0;
      acc_run    = 1'b1;
      case (req_kind)
         KIND_ADD_BACK: begin
            if (cnt_ff == LEN_MAX) acc_status = STAT_FULL;
            acc_addr = ring_add(head_ff, cnt_ff);
         end
         KIND_ADD_FRONT: begin
            if (cnt_ff == LEN_MAX) acc_status = STAT_FULL;
            acc_addr  = (head_ff == '0) ? LAST_IDX : head_ff - AW'(1);
            acc_paddr = cnt_ff[AW-1:0];
         end
         KIND_DROP_BACK: begin
            if (cnt_ff == '0) acc_status = STAT_EMPTY;
            acc_addr = ring_add(head_ff, cnt_m1);
         end
         KIND_DROP_FRONT: begin
            if (cnt_ff == '0) acc_status = STAT_EMPTY;
            acc_paddr = cnt_m1[AW-1:0];
         end
         KIND_SET, KIND_READ: begin
            if (bad_pos) acc_status = STAT_BAD_POS;
            acc_addr  = ring_add(head_ff, CW'(req_position));
            acc_paddr = k_off[AW-1:0];
         end
         KIND_CLEAR: ;
         default: acc_run = 1'b0;   // unused code: no state change
      endcase
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;        // build power tables first
         phase_ff     <= PH_RB;
         side_ff      <= 1'b0;
         boot_ff      <= 1'b1;
         idx_ff       <= '0;
         mod1_ff      <= RST_MOD_ONE;
         mod2_ff      <= RST_MOD_TWO;
         base_ff      <= RST_BASE;
         inv1_ff      <= RST_INV_ONE;
         inv2_ff      <= RST_INV_TWO;
         wm1_ff       <= RST_MOD_ONE;
         wm2_ff       <= RST_MOD_TWO;
         wbase_ff     <= RST_BASE;
         winv1_ff     <= RST_INV_ONE;
         winv2_ff     <= RST_INV_TWO;
         head_ff      <= '0;
         cnt_ff       <= '0;
         h1_ff        <= '0;
         h2_ff        <= '0;
         kind_ff      <= KIND_CLEAR;
         rsp_valid_ff <= 1'b0;
         status_ff    <= STAT_OK;
         rd_ff        <= '0;
      end else begin
         // strobe for the cycle after the finish state
         rsp_valid_ff <= (state_ff == S_FIN);

         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_MOD_ONE: mod1_ff <= csr_wr_data;
               CSR_MOD_TWO: mod2_ff <= csr_wr_data;
               CSR_BASE:    base_ff <= csr_wr_data;
               CSR_INV_ONE: inv1_ff <= csr_wr_data;
               CSR_INV_TWO: inv2_ff <= csr_wr_data;
               default: ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  wm1_ff    <= mod1_ff;
                  wm2_ff    <= mod2_ff;
                  wbase_ff  <= base_ff;
                  winv1_ff  <= inv1_ff;
                  winv2_ff  <= inv2_ff;
                  kind_ff   <= req_kind;
                  val_ff    <= req_value;
                  addr_ff   <= acc_addr;
                  paddr_ff  <= acc_paddr;
                  status_ff <= acc_status;
                  rd_ff     <= '0;
                  side_ff   <= 1'b0;
                  if (!acc_run || acc_status != STAT_OK) begin
                     state_ff <= S_FIN;
                  end else if (req_kind == KIND_CLEAR) begin
                     h1_ff    <= '0;
                     h2_ff    <= '0;
                     cnt_ff   <= '0;
                     head_ff  <= '0;
                     idx_ff   <= '0;
                     boot_ff  <= 1'b0;
                     phase_ff <= PH_RB;
                     state_ff <= S_LOAD;
                  end else begin
                     state_ff <= S_WAIT;
                  end
               end
            end
            S_WAIT: state_ff <= S_CAPT;   // RAM read latency
            S_CAPT: begin
               e_ff  <= st_rdata;
               p1_ff <= pw1_rdata;
               p2_ff <= pw2_rdata;
               if (kind_ff == KIND_READ) begin
                  rd_ff    <= st_rdata;
                  state_ff <= S_FIN;
               end else begin
                  phase_ff <= PH_H;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               if (ld_apply) begin
                  acc_ff   <= '0;
                  ea_ff    <= ld_a;
                  eb_ff    <= ld_b;
                  bit_ff   <= 5'd31;
                  state_ff <= S_RUN;
               end else if (phase_ff == PH_PW) begin
                  // entry zero written directly
                  if (side_ff) prev2_ff <= one_m;
                  else         prev1_ff <= one_m;
                  side_ff <= !side_ff;
                  if (side_ff) idx_ff <= idx_ff + AW'(1);
                  if (side_ff && idx_ff == LAST_IDX) begin
                     state_ff <= boot_ff ? S_IDLE : S_FIN;
                     boot_ff  <= 1'b0;
                  end
               end else begin
                  phase_ff <= next_phase(phase_ff);
               end
            end
            S_RUN: begin
               acc_ff <= step_res;
               ea_ff  <= ea_ff << 1;
               bit_ff <= bit_ff - 5'd1;
               if (bit_ff == '0) begin
                  case (phase_ff)
                     PH_H: hr_ff <= step_res;
                     PH_Y: y_ff  <= step_res;
                     PH_Z: z_ff  <= step_res;
                     PH_X: x_ff  <= step_res;
                     PH_M: t_ff  <= step_res;
                     PH_RB: begin
                        if (side_ff) rb2_ff <= step_res;
                        else         rb1_ff <= step_res;
                     end
                     default: begin
                        if (side_ff) prev2_ff <= step_res;
                        else         prev1_ff <= step_res;
                     end
                  endcase
                  case (phase_ff)
                     PH_RB: begin
                        side_ff  <= !side_ff;
                        if (side_ff) phase_ff <= PH_PW;
                        state_ff <= S_LOAD;
                     end
                     PH_PW: begin
                        side_ff <= !side_ff;
                        if (side_ff) idx_ff <= idx_ff + AW'(1);
                        if (side_ff && idx_ff == LAST_IDX) begin
                           state_ff <= boot_ff ? S_IDLE : S_FIN;
                           boot_ff  <= 1'b0;
                        end else begin
                           state_ff <= S_LOAD;
                        end
                     end
                     PH_M: state_ff <= S_FINAL;
                     default: begin
                        phase_ff <= next_phase(phase_ff);
                        state_ff <= S_LOAD;
                     end
                  endcase
               end
            end
            S_FINAL: begin
               if (side_ff) begin
                  h2_ff    <= hnew;
                  state_ff <= S_COMMIT;
               end else begin
                  h1_ff    <= hnew;
                  side_ff  <= 1'b1;
                  phase_ff <= PH_H;
                  state_ff <= S_LOAD;
               end
            end
            S_COMMIT: begin
               case (kind_ff)
                  KIND_ADD_BACK: cnt_ff <= cnt_ff + CW'(1);
                  KIND_ADD_FRONT: begin
                     head_ff <= addr_ff;
                     cnt_ff  <= cnt_ff + CW'(1);
                  end
                  KIND_DROP_BACK: begin
                     cnt_ff <= cnt_m1;
                     rd_ff  <= e_ff;
                  end
                  KIND_DROP_FRONT: begin
                     head_ff <= ring_add(head_ff, CW'(1));
                     cnt_ff  <= cnt_m1;
                     rd_ff   <= e_ff;
                  end
                  default: ;
               endcase
               state_ff <= S_FIN;
            end
            S_FIN: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ---------------- outputs ----------------
   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_hash_one   = h1_ff;
   assign rsp_hash_two   = h2_ff;
   assign rsp_length     = LenW'(cnt_ff);
   assign rsp_read_value = rd_ff;

endmodule

@@ rtl/dqrh_checker.sv @@
// Port-level checks for the double rolling hash deque, bound to the top level.
`timescale 1ns / 1ps
module dqrh_checker #(
   parameter int MAX_LEN = 1024
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input dqrh_pkg::stat_type rsp_status,
   input logic [10:0]        rsp_length,
   input dqrh_pkg::data_type rsp_read_value
);

   import dqrh_pkg::*;

   // a taken word always occupies the block
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_read_value == '0)
      else $error("failed word returned data");

   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $unsigned(rsp_length) <= MAX_LEN)
      else $error("length above capacity");

endmodule

bind deque_double_rolling_hash_core dqrh_checker #(.MAX_LEN(MAX_LEN)) u_dqrh_checker (.*);
